// ===== src/mdms_pkg.sv =====
// Shared types and constants for the Modbus data model server.
package mdms_pkg;

   localparam int CMD_W      = 3;
   localparam int FIELD_ADDR_W = 10;
   localparam int QTY_W      = 9;
   localparam int DIDX_W     = 8;
   localparam int WORD_W     = 16;
   localparam int BC_W       = 7;
   localparam int OFS_W      = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_RD_COILS    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RD_DISCRETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RD_HOLDING  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RD_INPUT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WR_HOLDING  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WR_COILS    = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_DATA,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
      logic hold_we;
      logic coil_we;
   } mem_ctl_type;

endpackage

// ===== src/mdms_store.sv =====
// Coil bit store and holding word store, one shared address, registered read.
module mdms_store #(
   parameter int ADDR_BITS = 10
) (
   input  logic                      clock,
   input  mdms_pkg::mem_ctl_type     ctl,
   input  logic [ADDR_BITS-1:0]      addr,
   input  logic [mdms_pkg::WORD_W-1:0] wr_word,
   input  logic                      wr_bit,
   output logic [mdms_pkg::WORD_W-1:0] hold_q,
   output logic                      coil_q
);
   import mdms_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WORD_W-1:0] hold_mem [DEPTH];
   logic              coil_mem [DEPTH];
   logic [WORD_W-1:0] hold_q_ff;
   logic              coil_q_ff;

   // clear pass writes zero, otherwise take the write data
   always_ff @(posedge clock) begin
      if (ctl.clear || ctl.hold_we) begin
         hold_mem[addr] <= ctl.clear ? '0 : wr_word;
      end
      if (ctl.clear || ctl.coil_we) begin
         coil_mem[addr] <= ctl.clear ? 1'b0 : wr_bit;
      end
      if (ctl.rd_en) begin
         hold_q_ff <= hold_mem[addr];
         coil_q_ff <= coil_mem[addr];
      end
   end

   assign hold_q = hold_q_ff;
   assign coil_q = coil_q_ff;

endmodule

// ===== src/modbus_data_model_server.sv =====
// Top level of the Modbus data model server: request sequencer and result register.
//
// Usage
//  - Request channel (req_*): one request per handshake. tuser carries the
//    command, tlast marks the final data item of a write request, tdata the
//    address, quantity, data index and write word.
//  - Result channel (rsp_*): one result per handshake. tuser echoes the
//    command, tlast marks the final result of a response.
//  - A single address adder walks the element offsets of a request; each
//    read element passes through an address state and a data state. Every
//    request is taken in idle. A bit read then collects each bit in an
//    address and a data state and sends each result byte from the emit
//    state; a register read goes through address, data and emit per word;
//    a holding write passes through the write state, a coil byte write stays
//    in it for each bit of the byte; an echo or an empty read result passes
//    through emit as well. req_tready is high only while the sequencer is idle.
//  - A result waits in an output register, so a new request is taken while
//    the last result of the previous one is still unclaimed. When the
//    receiver stalls, the sequencer holds at the next result until the
//    register frees.
//  - After reset the block sweeps both stores to zero, one entry per cycle,
//    all 2^STORE_ADDR_BITS entries (1024 at the default), with req_tready low.
module modbus_data_model_server #(
   parameter int STORE_ADDR_BITS = 10,
   parameter int MAX_READ_REGS   = 32,
   parameter int MAX_READ_BITS   = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] base_addr, [18:10] quantity, [26:19] data_index,
   // [42:27] write_data, [47:43] zero
   input  logic [mdms_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] cmd
   input  logic [mdms_pkg::CMD_W-1:0]        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [6:0] byte_count, [22:7] read_data, [32:23] echo_addr,
   // [41:33] echo_quantity, [47:42] zero
   output logic [mdms_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [2:0] echo_cmd
   output logic [mdms_pkg::CMD_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);
   import mdms_pkg::*;

   localparam int AW    = STORE_ADDR_BITS;
   localparam int SUM_W = (AW > OFS_W) ? AW : OFS_W;

   // request fields
   logic [CMD_W-1:0]        req_cmd;
   logic [FIELD_ADDR_W-1:0] req_start;
   logic [QTY_W-1:0]        req_qty;
   logic [DIDX_W-1:0]       req_didx;
   logic [WORD_W-1:0]       req_wdata;

   assign req_cmd   = req_tuser;
   assign req_start = req_tdata[9:0];
   assign req_qty   = req_tdata[18:10];
   assign req_didx  = req_tdata[26:19];
   assign req_wdata = req_tdata[42:27];

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [FIELD_ADDR_W-1:0] start_ff, start_in;
   logic [QTY_W-1:0]        qty_ff, qty_in;
   logic [WORD_W-1:0]       wdata_ff, wdata_in;
   logic                    lastd_ff, lastd_in;
   logic [OFS_W-1:0]        ofs_ff, ofs_in;
   logic [2:0]              bit_ff, bit_in;
   logic [WORD_W-1:0]       acc_ff, acc_in;
   logic [BC_W-1:0]         bc_ff, bc_in;
   logic                    fin_ff, fin_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           rd_addr_ff;

   logic                    rsp_v_ff, rsp_v_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [CMD_W-1:0]        rsp_cmd_ff;
   logic                    rsp_last_ff;

   // clamped read lengths and byte counts
   logic [QTY_W-1:0]        bits_n, regs_n;
   logic [QTY_W:0]          bits_sum;
   logic [BC_W-1:0]         bits_bc, regs_bc;

   // shared address adder
   logic [SUM_W-1:0]        addr_sum;
   logic [AW-1:0]           addr;
   logic [OFS_W-1:0]        ofs_plus;

   logic                    is_bit_read, is_wr, out_free, load_out, in_qty;
   logic                    rd_bit;
   logic [WORD_W-1:0]       rd_word;
   logic [7:0]              wbyte;
   logic [7:0]              bit_mask;
   logic [WORD_W-1:0]       hold_q;
   logic                    coil_q;
   mem_ctl_type             mem_ctl;
   logic [AW-1:0]           mem_addr;

   assign bits_n   = ({1'b0, req_qty} > (QTY_W+1)'(MAX_READ_BITS)) ?
                     QTY_W'(MAX_READ_BITS) : req_qty;
   assign regs_n   = ({1'b0, req_qty} > (QTY_W+1)'(MAX_READ_REGS)) ?
                     QTY_W'(MAX_READ_REGS) : req_qty;
   assign bits_sum = {1'b0, bits_n} + (QTY_W+1)'(7);
   assign bits_bc  = bits_sum[QTY_W:3];
   assign regs_bc  = {regs_n[BC_W-2:0], 1'b0};

   assign addr_sum = SUM_W'(start_ff) + SUM_W'(ofs_ff);
   assign addr     = addr_sum[AW-1:0];
   assign ofs_plus = ofs_ff + OFS_W'(1);
   assign in_qty   = ofs_ff < OFS_W'(qty_ff);

   always_comb begin
      is_bit_read = (cmd_ff == CMD_RD_COILS) || (cmd_ff == CMD_RD_DISCRETE);
      is_wr       = cmd_ff inside {CMD_WR_HOLDING, CMD_WR_COILS};
      rd_bit      = (cmd_ff == CMD_RD_COILS) ? coil_q : rd_addr_ff[0];
      rd_word     = (cmd_ff == CMD_RD_HOLDING) ? hold_q : WORD_W'(rd_addr_ff);
      wbyte       = wdata_ff[7:0];
      bit_mask    = rd_bit ? (8'h01 << bit_ff) : 8'h00;
      out_free    = !rsp_v_ff || rsp_tready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      start_in = start_ff;
      qty_in   = qty_ff;
      wdata_in = wdata_ff;
      lastd_in = lastd_ff;
      ofs_in   = ofs_ff;
      bit_in   = bit_ff;
      acc_in   = acc_ff;
      bc_in    = bc_ff;
      fin_in   = fin_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_cmd;
               start_in = req_start;
               wdata_in = req_wdata;
               lastd_in = req_tlast;
               bit_in   = '0;
               acc_in   = '0;
               bc_in    = '0;
               fin_in   = 1'b1;
               ofs_in   = '0;
               qty_in   = req_qty;
               case (req_cmd)
                  CMD_RD_COILS, CMD_RD_DISCRETE: begin
                     qty_in   = bits_n;
                     bc_in    = bits_bc;
                     fin_in   = (bits_n == '0);
                     state_in = (bits_n == '0) ? ST_EMIT : ST_ADDR;
                  end
                  CMD_RD_HOLDING, CMD_RD_INPUT: begin
                     qty_in   = regs_n;
                     bc_in    = regs_bc;
                     fin_in   = (regs_n == '0);
                     state_in = (regs_n == '0) ? ST_EMIT : ST_ADDR;
                  end
                  CMD_WR_HOLDING: begin
                     ofs_in   = OFS_W'(req_didx);
                     state_in = ST_WRITE;
                  end
                  CMD_WR_COILS: begin
                     ofs_in   = {1'b0, req_didx, 3'b000};
                     state_in = ST_WRITE;
                  end
                  default: begin
                     // unknown command: drop it
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADDR: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            ofs_in = ofs_plus;
            fin_in = (ofs_plus == OFS_W'(qty_ff));
            if (is_bit_read) begin
               acc_in = {8'h00, acc_ff[7:0] | bit_mask};
               bit_in = bit_ff + 3'd1;
               state_in = ((bit_ff == 3'd7) || (ofs_plus == OFS_W'(qty_ff))) ?
                          ST_EMIT : ST_ADDR;
            end else begin
               acc_in   = rd_word;
               state_in = ST_EMIT;
            end
         end
         ST_WRITE: begin
            if (cmd_ff == CMD_WR_COILS) begin
               bit_in = bit_ff + 3'd1;
               ofs_in = ofs_plus;
               if (bit_ff == 3'd7) begin
                  state_in = lastd_ff ? ST_EMIT : ST_IDLE;
               end
            end else begin
               state_in = lastd_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (fin_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ADDR;
                  acc_in   = '0;
                  bit_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready      = (state_ff == ST_IDLE);
      mem_ctl.clear   = (state_ff == ST_CLEAR);
      mem_ctl.rd_en   = (state_ff == ST_ADDR);
      mem_ctl.hold_we = (state_ff == ST_WRITE) && (cmd_ff == CMD_WR_HOLDING);
      mem_ctl.coil_we = (state_ff == ST_WRITE) && (cmd_ff == CMD_WR_COILS) && in_qty;
      mem_addr        = (state_ff == ST_CLEAR) ? clr_ff : addr;
      load_out        = (state_ff == ST_EMIT) && out_free;
      rsp_v_in        = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      start_ff <= start_in;
      qty_ff   <= qty_in;
      wdata_ff <= wdata_in;
      lastd_ff <= lastd_in;
      ofs_ff   <= ofs_in;
      bit_ff   <= bit_in;
      acc_ff   <= acc_in;
      bc_ff    <= bc_in;
      fin_ff   <= fin_in;
      if (mem_ctl.rd_en) begin
         rd_addr_ff <= addr;
      end
      if (load_out) begin
         rsp_cmd_ff  <= cmd_ff;
         rsp_last_ff <= fin_ff;
         rsp_data_ff <= {6'b000000,
                         is_wr ? qty_ff : QTY_W'(0),
                         is_wr ? start_ff : FIELD_ADDR_W'(0),
                         acc_ff,
                         bc_ff};
      end
   end

   mdms_store #(
      .ADDR_BITS (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_word (wdata_ff),
      .wr_bit  (wbyte[bit_ff]),
      .hold_q  (hold_q),
      .coil_q  (coil_q)
   );

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_cmd_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // a read step only ever touches an offset inside the clamped quantity
   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> (ofs_ff < OFS_W'(qty_ff)))
      else $error("read step beyond quantity");

   // a write echo is a single result with no data bytes
   a_echo_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == CMD_WR_HOLDING || rsp_tuser == CMD_WR_COILS))
      |-> (rsp_tlast && (rsp_tdata[6:0] == '0)))
      else $error("malformed write echo");

   // only read responses span more than one result
   a_multi_read_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |->
      (rsp_tuser == CMD_RD_COILS || rsp_tuser == CMD_RD_DISCRETE ||
       rsp_tuser == CMD_RD_HOLDING || rsp_tuser == CMD_RD_INPUT))
      else $error("non-last result outside a read");

   // a known command leaves the sequencer busy in the cycle after it is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == CMD_RD_COILS ||
       req_tuser == CMD_RD_DISCRETE || req_tuser == CMD_RD_HOLDING ||
       req_tuser == CMD_RD_INPUT || req_tuser == CMD_WR_HOLDING ||
       req_tuser == CMD_WR_COILS)) |=> !req_tready)
      else $error("request accepted without busy period");
`endif

endmodule
